@@ rtl/core/mvc_pkg.sv @@
package mvc_pkg;

    // Coordinate and accumulator geometry
    localparam int COORD_BITS = 16;
    localparam int ACC_W      = 64;
    localparam int S_W        = COORD_BITS + 2;        // a+b+c
    localparam int K_W        = 2 * COORD_BITS + 1;    // cross product term, also scaled triple
    localparam int T_W        = 3 * COORD_BITS + 1;    // triple product
    localparam int P_W        = K_W + S_W;             // multiplier lane product

    // Centroid long division: quotient bits and the shift split of the dividend
    localparam int Q_W        = COORD_BITS + 1;
    localparam int FRAC_STEPS = COORD_BITS - 2;
    localparam int PRE_SH     = Q_W - FRAC_STEPS;

    // Volume: six times the volume divided by six, VOL_STEP_BITS bits per step
    localparam int VOL_DIV       = 6;
    localparam int VOL_REM_W     = $clog2(VOL_DIV);
    localparam int VOL_STEP_BITS = 4;
    localparam int VOL_STEPS     = ACC_W / VOL_STEP_BITS;

    localparam int DIV_CYCLES = (Q_W > VOL_STEPS) ? Q_W : VOL_STEPS;
    localparam int CNT_W      = $clog2(DIV_CYCLES + 1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [S_W-1:0]        t_s;
    typedef logic signed [K_W-1:0]        t_k;
    typedef logic signed [T_W-1:0]        t_t;
    typedef logic signed [P_W-1:0]        t_p;
    typedef logic signed [ACC_W-1:0]      t_acc;
    typedef logic        [ACC_W-1:0]      t_uacc;
    typedef logic        [Q_W-1:0]        t_q;
    typedef logic        [CNT_W-1:0]      t_cnt;
    typedef logic        [VOL_REM_W-1:0]  t_vrem;
    typedef logic        [VOL_REM_W:0]    t_vrem4;

    localparam t_acc   ACC_MAX     = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc   ACC_MIN     = {1'b1, {(ACC_W-1){1'b0}}};
    localparam t_q     CEN_POS_LIM = t_q'((1 << (COORD_BITS - 1)) - 1);
    localparam t_q     CEN_NEG_LIM = t_q'(1 << (COORD_BITS - 1));
    localparam t_vrem4 VOL_DIV_W   = t_vrem4'(VOL_DIV);

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CROSS2,
        OP_TRIPLE,
        OP_SUM,
        OP_SCALE,
        OP_WEIGHT,
        OP_ACCUM,
        OP_DIV_PREP,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_FINISH
    } t_op;

    // Controller to datapath
    typedef struct packed {
        t_op  op;
        logic load;      // take a triangle and start the first cross products
        logic cen_en;    // centroid lanes step this cycle
        logic vol_en;    // volume lane steps this cycle
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last;
        logic out_free;
    } t_stat;

    // Datapath to divider unit
    typedef struct packed {
        logic load;
        logic cen_step;
        logic vol_step;
    } t_div_cmd;

    typedef struct packed {
        t_coord a_x;
        t_coord a_y;
        t_coord a_z;
        t_coord b_x;
        t_coord b_y;
        t_coord b_z;
        t_coord c_x;
        t_coord c_y;
        t_coord c_z;
        logic   last_triangle;
    } t_tri;

    typedef struct packed {
        t_coord  center_x;
        t_coord  center_y;
        t_coord  center_z;
        t_acc    mesh_volume;
        t_status status;
    } t_res;

    typedef struct packed {
        logic ovf;
        t_acc val;
    } t_sat;

    // Signed add that clamps to the accumulator range and flags the clamp
    function automatic t_sat sat_add(t_acc x, t_acc y);
        t_acc s;
        t_sat r;
        s     = x + y;
        r.ovf = (x[ACC_W-1] == y[ACC_W-1]) && (s[ACC_W-1] != x[ACC_W-1]);
        if (r.ovf) begin
            r.val = x[ACC_W-1] ? ACC_MIN : ACC_MAX;
        end else begin
            r.val = s;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/mvc_tri_if.sv @@
interface mvc_tri_if;
    logic                 valid;
    logic                 ready;
    mvc_pkg::t_coord      a_x;
    mvc_pkg::t_coord      a_y;
    mvc_pkg::t_coord      a_z;
    mvc_pkg::t_coord      b_x;
    mvc_pkg::t_coord      b_y;
    mvc_pkg::t_coord      b_z;
    mvc_pkg::t_coord      c_x;
    mvc_pkg::t_coord      c_y;
    mvc_pkg::t_coord      c_z;
    logic                 last_triangle;

    modport source (
        output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, last_triangle,
        input  ready
    );

    modport sink (
        input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, last_triangle,
        output ready
    );
endinterface

@@ rtl/core/mvc_res_if.sv @@
interface mvc_res_if;
    logic              valid;
    logic              ready;
    mvc_pkg::t_coord   center_x;
    mvc_pkg::t_coord   center_y;
    mvc_pkg::t_coord   center_z;
    mvc_pkg::t_acc     mesh_volume;
    mvc_pkg::t_status  status;

    modport source (
        output valid, center_x, center_y, center_z, mesh_volume, status,
        input  ready
    );

    modport sink (
        input  valid, center_x, center_y, center_z, mesh_volume, status,
        output ready
    );
endinterface

@@ rtl/core/mesh_volume_centroid.sv @@
// Volume and centroid of a closed triangle mesh by the divergence method.
// i_tri takes one triangle per item (three Q3.12 vertices and a last flag);
// o_res gives one item per mesh when the triangle marked last has been
// summed: centroid in Q3.12, volume with 36 fractional bits, and status.
// Both channels move an item when valid and ready are high at a clock edge.
// Three shared multiplier lanes run the cross product (two passes), the
// triple product and the weighted terms in turn; the next triangle is
// taken during the accumulate cycle. The result of a mesh comes from a
// long division on the sums once the last triangle has been accepted
// (three centroid lanes and a divide-by-six lane run side by side).
// A new triangle is taken once that result has gone to the output
// register.
// Reset (synchronous, active low) clears the sums, the overflow flag, the
// sequencer and the output valid. If the receiver stalls, the result waits
// in the output register and triangles keep flowing; once the next mesh's
// last triangle has been summed, its result is held back and no triangle
// is taken until that register empties.
module mesh_volume_centroid (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mvc_tri_if.sink   i_tri,
    mvc_res_if.source o_res
);

    mvc_pkg::t_tri  c_tri;
    mvc_pkg::t_cmd  c_cmd;
    mvc_pkg::t_stat c_stat;
    mvc_pkg::t_res  c_res;
    logic           c_in_ready;
    logic           c_res_valid;

    // Input item into the package struct
    assign c_tri.a_x           = i_tri.a_x;
    assign c_tri.a_y           = i_tri.a_y;
    assign c_tri.a_z           = i_tri.a_z;
    assign c_tri.b_x           = i_tri.b_x;
    assign c_tri.b_y           = i_tri.b_y;
    assign c_tri.b_z           = i_tri.b_z;
    assign c_tri.c_x           = i_tri.c_x;
    assign c_tri.c_y           = i_tri.c_y;
    assign c_tri.c_z           = i_tri.c_z;
    assign c_tri.last_triangle = i_tri.last_triangle;
    assign i_tri.ready         = c_in_ready;

    mvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_tri.valid),
        .i_stat     (c_stat),
        .o_in_ready (c_in_ready),
        .o_cmd      (c_cmd)
    );

    mvc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (c_cmd),
        .i_tri       (c_tri),
        .i_res_ready (o_res.ready),
        .o_stat      (c_stat),
        .o_res_valid (c_res_valid),
        .o_res       (c_res)
    );

    // Result item onto the output channel
    assign o_res.valid       = c_res_valid;
    assign o_res.center_x    = c_res.center_x;
    assign o_res.center_y    = c_res.center_y;
    assign o_res.center_z    = c_res.center_z;
    assign o_res.mesh_volume = c_res.mesh_volume;
    assign o_res.status      = c_res.status;

endmodule

@@ rtl/core/mvc_div.sv @@
module mvc_div (
    input  logic               i_clk,
    input  mvc_pkg::t_div_cmd  i_cmd,
    input  mvc_pkg::t_uacc     i_uw [3],
    input  mvc_pkg::t_uacc     i_ut,
    output mvc_pkg::t_q        o_q [3],
    output logic [2:0]         o_sat,
    output mvc_pkg::t_uacc     o_vq
);

    mvc_pkg::t_uacc r_ut;
    mvc_pkg::t_uacc r_rem [3];
    mvc_pkg::t_q    r_lo  [3];
    mvc_pkg::t_q    r_q   [3];
    logic [2:0]     r_sat;

    mvc_pkg::t_uacc r_vsh;
    mvc_pkg::t_vrem r_vrem;
    mvc_pkg::t_uacc r_vq;

    logic [mvc_pkg::ACC_W:0]           c_rem2 [3];
    logic [2:0]                        c_ge;
    mvc_pkg::t_uacc                    c_rem  [3];
    logic [2:0]                        c_pre;
    mvc_pkg::t_vrem                    c_vrem;
    logic [mvc_pkg::VOL_STEP_BITS-1:0] c_vbits;

    // Centroid lanes: one restoring step each, shared divisor
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_rem2[i] = {r_rem[i], r_lo[i][mvc_pkg::Q_W-1]};
            c_ge[i]   = c_rem2[i] >= {1'b0, r_ut};
            c_rem[i]  = c_ge[i] ? mvc_pkg::t_uacc'(c_rem2[i] - {1'b0, r_ut})
                                : c_rem2[i][mvc_pkg::ACC_W-1:0];
            // quotient would need more bits than the result can hold
            c_pre[i]  = {{mvc_pkg::PRE_SH{1'b0}}, i_uw[i]} >=
                        {i_ut, {mvc_pkg::PRE_SH{1'b0}}};
        end
    end

    // Volume lane: VOL_STEP_BITS binary digits of the divide by six per step
    always_comb begin
        mvc_pkg::t_vrem4 rem4;
        mvc_pkg::t_vrem  rem;
        rem     = r_vrem;
        c_vbits = '0;
        for (int j = 0; j < mvc_pkg::VOL_STEP_BITS; j++) begin
            rem4 = {rem, r_vsh[mvc_pkg::ACC_W-1-j]};
            if (rem4 >= mvc_pkg::VOL_DIV_W) begin
                rem = mvc_pkg::t_vrem'(rem4 - mvc_pkg::VOL_DIV_W);
                c_vbits[mvc_pkg::VOL_STEP_BITS-1-j] = 1'b1;
            end else begin
                rem = rem4[mvc_pkg::VOL_REM_W-1:0];
            end
        end
        c_vrem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ut   <= i_ut;
            r_sat  <= c_pre;
            r_vsh  <= i_ut;
            r_vrem <= '0;
            r_vq   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_rem[i] <= i_uw[i] >> mvc_pkg::PRE_SH;
                r_lo[i]  <= {i_uw[i][mvc_pkg::PRE_SH-1:0], {mvc_pkg::FRAC_STEPS{1'b0}}};
                r_q[i]   <= '0;
            end
        end else begin
            if (i_cmd.cen_step) begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= c_rem[i];
                    r_lo[i]  <= {r_lo[i][mvc_pkg::Q_W-2:0], 1'b0};
                    r_q[i]   <= {r_q[i][mvc_pkg::Q_W-2:0], c_ge[i]};
                end
            end
            if (i_cmd.vol_step) begin
                r_vsh  <= r_vsh << mvc_pkg::VOL_STEP_BITS;
                r_vrem <= c_vrem;
                r_vq   <= {r_vq[mvc_pkg::ACC_W-mvc_pkg::VOL_STEP_BITS-1:0], c_vbits};
            end
        end
    end

    assign o_q   = r_q;
    assign o_sat = r_sat;
    assign o_vq  = r_vq;

endmodule

@@ rtl/core/mvc_dpath.sv @@
module mvc_dpath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mvc_pkg::t_cmd   i_cmd,
    input  mvc_pkg::t_tri   i_tri,
    input  logic            i_res_ready,
    output mvc_pkg::t_stat  o_stat,
    output logic            o_res_valid,
    output mvc_pkg::t_res   o_res
);

    // Held triangle and intermediate products
    mvc_pkg::t_coord r_a [3];
    mvc_pkg::t_coord r_b [3];
    mvc_pkg::t_coord r_c [3];
    logic            r_last;
    mvc_pkg::t_s     r_s [3];
    mvc_pkg::t_p     r_p [3];
    mvc_pkg::t_k     r_k [3];
    mvc_pkg::t_t     r_t;
    mvc_pkg::t_k     r_tq;

    // Running sums
    mvc_pkg::t_acc   r_six;
    mvc_pkg::t_acc   r_w [3];
    logic            r_ovf;

    // Divide set-up
    mvc_pkg::t_uacc  r_uw [3];
    mvc_pkg::t_uacc  r_ut;
    logic [2:0]      r_neg;
    logic            r_vneg;
    logic            r_zero;

    // Result register
    logic            r_out_valid;
    mvc_pkg::t_res   r_res;

    mvc_pkg::t_coord   c_ia [3];
    mvc_pkg::t_coord   c_ib [3];
    mvc_pkg::t_coord   c_ic [3];
    mvc_pkg::t_k       m_a  [3];
    mvc_pkg::t_s       m_b  [3];
    mvc_pkg::t_p       m_p  [3];
    mvc_pkg::t_sat     c_sat_six;
    mvc_pkg::t_sat     c_sat_w [3];
    logic              c_round;
    mvc_pkg::t_div_cmd c_div_cmd;
    mvc_pkg::t_q       div_q [3];
    logic [2:0]        div_sat;
    mvc_pkg::t_uacc    div_vq;
    mvc_pkg::t_q       c_lim [3];
    mvc_pkg::t_q       c_mag [3];
    mvc_pkg::t_q       c_cen [3];
    mvc_pkg::t_acc     c_vol;
    mvc_pkg::t_status  c_status;

    assign c_ia[0] = i_tri.a_x;
    assign c_ia[1] = i_tri.a_y;
    assign c_ia[2] = i_tri.a_z;
    assign c_ib[0] = i_tri.b_x;
    assign c_ib[1] = i_tri.b_y;
    assign c_ib[2] = i_tri.b_z;
    assign c_ic[0] = i_tri.c_x;
    assign c_ic[1] = i_tri.c_y;
    assign c_ic[2] = i_tri.c_z;

    // Operand select for the three shared multiplier lanes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m_a[i] = '0;
            m_b[i] = '0;
        end
        if (i_cmd.load) begin
            // first terms of a x b, straight from the input item
            m_a[0] = mvc_pkg::t_k'(c_ia[1]);  m_b[0] = mvc_pkg::t_s'(c_ib[2]);
            m_a[1] = mvc_pkg::t_k'(c_ia[2]);  m_b[1] = mvc_pkg::t_s'(c_ib[0]);
            m_a[2] = mvc_pkg::t_k'(c_ia[0]);  m_b[2] = mvc_pkg::t_s'(c_ib[1]);
        end else begin
            case (i_cmd.op)
                mvc_pkg::OP_CROSS2: begin
                    m_a[0] = mvc_pkg::t_k'(r_a[2]);  m_b[0] = mvc_pkg::t_s'(r_b[1]);
                    m_a[1] = mvc_pkg::t_k'(r_a[0]);  m_b[1] = mvc_pkg::t_s'(r_b[2]);
                    m_a[2] = mvc_pkg::t_k'(r_a[1]);  m_b[2] = mvc_pkg::t_s'(r_b[0]);
                end
                mvc_pkg::OP_TRIPLE: begin
                    for (int i = 0; i < 3; i++) begin
                        m_a[i] = r_k[i];
                        m_b[i] = mvc_pkg::t_s'(r_c[i]);
                    end
                end
                mvc_pkg::OP_WEIGHT: begin
                    for (int i = 0; i < 3; i++) begin
                        m_a[i] = r_tq;
                        m_b[i] = r_s[i];
                    end
                end
                default: begin
                end
            endcase
        end
        for (int i = 0; i < 3; i++) begin
            m_p[i] = mvc_pkg::t_p'(m_a[i]) * mvc_pkg::t_p'(m_b[i]);
        end
    end

    // Triple product scaled down, truncated toward zero
    assign c_round = r_t[mvc_pkg::T_W-1] & (|r_t[mvc_pkg::COORD_BITS-1:0]);

    // Saturating accumulation
    always_comb begin
        c_sat_six = mvc_pkg::sat_add(r_six, mvc_pkg::t_acc'(r_t));
        for (int i = 0; i < 3; i++) begin
            c_sat_w[i] = mvc_pkg::sat_add(r_w[i], mvc_pkg::t_acc'(r_p[i]));
        end
    end

    // Per-triangle pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_last <= i_tri.last_triangle;
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= c_ia[i];
                r_b[i] <= c_ib[i];
                r_c[i] <= c_ic[i];
                r_s[i] <= mvc_pkg::t_s'(c_ia[i]) + mvc_pkg::t_s'(c_ib[i])
                        + mvc_pkg::t_s'(c_ic[i]);
                r_p[i] <= m_p[i];
            end
        end
        case (i_cmd.op)
            mvc_pkg::OP_CROSS2: begin
                for (int i = 0; i < 3; i++) begin
                    r_k[i] <= mvc_pkg::t_k'(r_p[i]) - mvc_pkg::t_k'(m_p[i]);
                end
            end
            mvc_pkg::OP_TRIPLE, mvc_pkg::OP_WEIGHT: begin
                for (int i = 0; i < 3; i++) begin
                    r_p[i] <= m_p[i];
                end
            end
            mvc_pkg::OP_SUM: begin
                r_t <= mvc_pkg::t_t'(r_p[0]) + mvc_pkg::t_t'(r_p[1])
                     + mvc_pkg::t_t'(r_p[2]);
            end
            mvc_pkg::OP_SCALE: begin
                r_tq <= mvc_pkg::t_k'(r_t >>> mvc_pkg::COORD_BITS)
                      + mvc_pkg::t_k'(c_round);
            end
            mvc_pkg::OP_DIV_PREP: begin
                r_ut   <= r_six[mvc_pkg::ACC_W-1] ? mvc_pkg::t_uacc'(-r_six)
                                                  : mvc_pkg::t_uacc'(r_six);
                r_vneg <= r_six[mvc_pkg::ACC_W-1];
                r_zero <= (r_six == '0);
                for (int i = 0; i < 3; i++) begin
                    r_uw[i]  <= r_w[i][mvc_pkg::ACC_W-1] ? mvc_pkg::t_uacc'(-r_w[i])
                                                         : mvc_pkg::t_uacc'(r_w[i]);
                    r_neg[i] <= r_w[i][mvc_pkg::ACC_W-1] ^ r_six[mvc_pkg::ACC_W-1];
                end
            end
            default: begin
            end
        endcase
    end

    // Mesh accumulators, cleared once a result goes to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_six <= '0;
            r_ovf <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_w[i] <= '0;
            end
        end else begin
            case (i_cmd.op)
                mvc_pkg::OP_SCALE: begin
                    r_six <= c_sat_six.val;
                    r_ovf <= r_ovf | c_sat_six.ovf;
                end
                mvc_pkg::OP_ACCUM: begin
                    for (int i = 0; i < 3; i++) begin
                        r_w[i] <= c_sat_w[i].val;
                    end
                    r_ovf <= r_ovf | c_sat_w[0].ovf | c_sat_w[1].ovf | c_sat_w[2].ovf;
                end
                mvc_pkg::OP_FINISH: begin
                    r_six <= '0;
                    r_ovf <= 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        r_w[i] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Divider unit
    assign c_div_cmd.load     = (i_cmd.op == mvc_pkg::OP_DIV_LOAD);
    assign c_div_cmd.cen_step = (i_cmd.op == mvc_pkg::OP_DIV_STEP) && i_cmd.cen_en;
    assign c_div_cmd.vol_step = (i_cmd.op == mvc_pkg::OP_DIV_STEP) && i_cmd.vol_en;

    mvc_div u_div (
        .i_clk (i_clk),
        .i_cmd (c_div_cmd),
        .i_uw  (r_uw),
        .i_ut  (r_ut),
        .o_q   (div_q),
        .o_sat (div_sat),
        .o_vq  (div_vq)
    );

    // Final clamp, sign and status
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_lim[i] = r_neg[i] ? mvc_pkg::CEN_NEG_LIM : mvc_pkg::CEN_POS_LIM;
            c_mag[i] = (div_sat[i] || (div_q[i] > c_lim[i])) ? c_lim[i] : div_q[i];
            if (r_zero) begin
                c_cen[i] = '0;
            end else if (r_neg[i]) begin
                c_cen[i] = mvc_pkg::t_q'(-c_mag[i]);
            end else begin
                c_cen[i] = c_mag[i];
            end
        end
        c_vol = r_vneg ? mvc_pkg::t_acc'(-div_vq) : mvc_pkg::t_acc'(div_vq);
        if (r_ovf) begin
            c_status = mvc_pkg::ST_OVF;
        end else if (r_zero) begin
            c_status = mvc_pkg::ST_ZERO;
        end else begin
            c_status = mvc_pkg::ST_OK;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == mvc_pkg::OP_FINISH) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == mvc_pkg::OP_FINISH) begin
            r_res.center_x    <= c_cen[0][mvc_pkg::COORD_BITS-1:0];
            r_res.center_y    <= c_cen[1][mvc_pkg::COORD_BITS-1:0];
            r_res.center_z    <= c_cen[2][mvc_pkg::COORD_BITS-1:0];
            r_res.mesh_volume <= c_vol;
            r_res.status      <= c_status;
        end
    end

    assign o_stat.last     = r_last;
    assign o_stat.out_free = !r_out_valid || i_res_ready;
    assign o_res_valid     = r_out_valid;
    assign o_res           = r_res;

endmodule

@@ rtl/core/mvc_ctrl.sv @@
module mvc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  mvc_pkg::t_stat  i_stat,
    output logic            o_in_ready,
    output mvc_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CROSS2,
        S_TRIPLE,
        S_SUM,
        S_SCALE,
        S_WEIGHT,
        S_ACCUM,
        S_PREP,
        S_LOAD,
        S_DIVIDE,
        S_FINISH
    } t_state;

    t_state        r_state;
    t_state        n_state;
    mvc_pkg::t_cnt r_cnt;
    mvc_pkg::t_cnt n_cnt;

    // Sequencing of one triangle, then the divide on the last one
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_in_ready    = 1'b0;
        o_cmd.op      = mvc_pkg::OP_NONE;
        o_cmd.load    = 1'b0;
        o_cmd.cen_en  = 1'b0;
        o_cmd.vol_en  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CROSS2;
                end
            end
            S_CROSS2: begin
                o_cmd.op = mvc_pkg::OP_CROSS2;
                n_state  = S_TRIPLE;
            end
            S_TRIPLE: begin
                o_cmd.op = mvc_pkg::OP_TRIPLE;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = mvc_pkg::OP_SUM;
                n_state  = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.op = mvc_pkg::OP_SCALE;
                n_state  = S_WEIGHT;
            end
            S_WEIGHT: begin
                o_cmd.op = mvc_pkg::OP_WEIGHT;
                n_state  = S_ACCUM;
            end
            S_ACCUM: begin
                // the adders finish this triangle while the next one enters
                o_cmd.op = mvc_pkg::OP_ACCUM;
                if (i_stat.last) begin
                    n_state = S_PREP;
                end else begin
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_CROSS2;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_PREP: begin
                o_cmd.op = mvc_pkg::OP_DIV_PREP;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.op = mvc_pkg::OP_DIV_LOAD;
                n_cnt    = '0;
                n_state  = S_DIVIDE;
            end
            S_DIVIDE: begin
                o_cmd.op     = mvc_pkg::OP_DIV_STEP;
                o_cmd.cen_en = r_cnt < mvc_pkg::t_cnt'(mvc_pkg::Q_W);
                o_cmd.vol_en = r_cnt < mvc_pkg::t_cnt'(mvc_pkg::VOL_STEPS);
                n_cnt        = r_cnt + mvc_pkg::t_cnt'(1);
                if (r_cnt == mvc_pkg::t_cnt'(mvc_pkg::DIV_CYCLES - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.op = mvc_pkg::OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
